FILE: sv/pspc_pkg.sv
// Shared types, constants and hash function for the per-source packet counter.
package pspc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = INDEX_W + 1;
    localparam int ADDR_W        = 32;
    localparam int LEN_W         = 16;
    localparam int COUNT_W       = 64;
    localparam int RES_W         = 3;

    localparam logic [LEN_W-1:0]   MIN_FRAME_BYTES = LEN_W'(34);
    localparam logic [RES_W-1:0]   EVENT_LAST_RES  = RES_W'(4);   // period of five, minus one
    localparam logic [INDEX_W-1:0] LAST_INDEX      = INDEX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]   FULL_PROBES     = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    // One table slot; res holds count modulo five
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  key;
        logic [COUNT_W-1:0] count;
        logic [RES_W-1:0]   res;
    } entry_t;

    typedef struct packed {
        logic               hit;
        logic               empty;
        logic               event_hit;
        logic [COUNT_W-1:0] new_count;
        logic [RES_W-1:0]   new_res;
    } unit_res_t;

    // XOR fold of the address down to an index, kept below TABLE_ENTRIES
    function automatic logic [INDEX_W-1:0] home_slot(input logic [ADDR_W-1:0] addr);
        logic [INDEX_W-1:0] h;
        logic [CNT_W-1:0]   wide;
        h = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            h[i % INDEX_W] = h[i % INDEX_W] ^ addr[i];
        end
        wide = {1'b0, h};
        if (wide >= FULL_PROBES)
        begin
            wide = wide - FULL_PROBES;
        end
        return wide[INDEX_W-1:0];
    endfunction

endpackage

FILE: sv/pspc_table.sv
// Slot memory: one write port, one read port with registered data.
module pspc_table
    import pspc_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [INDEX_W-1:0] waddr,
    input  entry_t             wdata,
    input  logic [INDEX_W-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

FILE: sv/pspc_unit.sv
// Probe unit: key compare, count increment and modulo-five tracking.
module pspc_unit
    import pspc_pkg::*;
(
    input  entry_t            slot,
    input  logic [ADDR_W-1:0] key,
    output unit_res_t         res
);

    logic all_ones;

    assign all_ones = &slot.count;

    always_comb
    begin
        res.empty     = !slot.valid;
        res.hit       = slot.valid && (slot.key == key);
        res.new_count = slot.count + COUNT_W'(1);
        // 2^64 - 1 is a multiple of five, so the wrap lands back on zero
        if (all_ones || slot.res == EVENT_LAST_RES)
        begin
            res.new_res = '0;
        end
        else
        begin
            res.new_res = slot.res + RES_W'(1);
        end
        res.event_hit = (res.new_res == '0);
    end

endmodule

FILE: sv/per_source_packet_counter.sv
// Top level of the per-source packet counter: sequencer, table and event register.
//
// Input beats on s_axis carry a frame length and IPv4 source address. Frames
// under 34 bytes are dropped. Others are hashed to a home slot of
// a TABLE_ENTRIES-slot table and probed linearly, one slot per cycle through
// the single read port of the slot memory.
// A hit bumps the slot's 64-bit count; when the new count is a multiple of
// five an event beat (address, count) goes out on m_axis. A miss inserts the
// address with count one. A miss on a full table drops the frame.
// Steps per beat: a short frame leaves the sequencer idle; a hit passes from the
// look state to the update state, which writes the slot back; an insert writes
// the empty slot from the look state; a full-table miss probes every slot.
// s_axis_tready is high only while the sequencer is idle.
// After reset a clearing pass over all TABLE_ENTRIES slots (1024) zeroes every
// slot's valid flag; no beat is taken until it is done.
// The event beat sits in an output register, so new inputs are taken while it
// waits; a second event stalls the sequencer until m_axis_tready frees it.
module per_source_packet_counter
    import pspc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] frame_length, [47:16] source_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [31:0] event_address, [95:32] event_count
);

    state_t state_reg, state_next;

    logic [INDEX_W-1:0] clr_idx_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [CNT_W-1:0]   probes_reg;
    logic [ADDR_W-1:0]  key_reg;
    logic [COUNT_W-1:0] upd_count_reg;
    logic [RES_W-1:0]   upd_res_reg;
    logic               upd_event_reg;
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               in_accept;
    logic               long_frame;
    logic [ADDR_W-1:0]  in_addr;
    logic [INDEX_W-1:0] next_idx;
    logic               out_free;

    logic               mem_we;
    logic [INDEX_W-1:0] mem_waddr;
    entry_t             mem_wdata;
    logic [INDEX_W-1:0] mem_raddr;
    entry_t             mem_rdata;
    unit_res_t          unit_res;
    logic               out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign long_frame    = (s_axis_tdata[15:0] >= MIN_FRAME_BYTES);
    assign in_addr       = s_axis_tdata[47:16];
    assign next_idx      = (idx_reg == LAST_INDEX) ? '0 : idx_reg + INDEX_W'(1);
    assign out_free      = !out_valid_reg || m_axis_tready;

    pspc_table u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pspc_unit u_unit (
        .slot (mem_rdata),
        .key  (key_reg),
        .res  (unit_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_INDEX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && long_frame)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (unit_res.empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (unit_res.hit)
                begin
                    state_next = ST_UPDATE;
                end
                else if (probes_reg == FULL_PROBES)
                begin
                    state_next = ST_IDLE;   // table full, frame not counted
                end
            end
            ST_UPDATE:
            begin
                if (!upd_event_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory and output-register control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_raddr = next_idx;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
            end
            ST_IDLE:
            begin
                mem_raddr = home_slot(in_addr);
            end
            ST_LOOK:
            begin
                if (unit_res.empty)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{valid: 1'b1, key: key_reg,
                                  count: COUNT_W'(1), res: RES_W'(1)};
                end
            end
            ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{valid: 1'b1, key: key_reg,
                              count: upd_count_reg, res: upd_res_reg};
                out_load  = upd_event_reg && out_free;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + INDEX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Probe bookkeeping and payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg    <= in_addr;
            idx_reg    <= home_slot(in_addr);
            probes_reg <= CNT_W'(1);
        end
        else if (state_reg == ST_LOOK)
        begin
            probes_reg <= probes_reg + CNT_W'(1);
            if (unit_res.hit)
            begin
                upd_count_reg <= unit_res.new_count;
                upd_res_reg   <= unit_res.new_res;
                upd_event_reg <= unit_res.event_hit;
            end
            else
            begin
                idx_reg <= next_idx;
            end
        end
        if (out_load)
        begin
            out_addr_reg  <= key_reg;
            out_count_reg <= upd_count_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_addr_reg};

endmodule

FILE: sv/pspc_checker.sv
// Port-level checker for the per-source packet counter, bound to the top level.
module pspc_checker
    import pspc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    // A stalled event beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("event beat changed while stalled");

    // Every reported count is a multiple of five
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[95:32] % 64'd5) == 64'd0))
        else $error("event count not a multiple of five");

    // A counted frame keeps the input closed for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[15:0] >= MIN_FRAME_BYTES))
        |=> !s_axis_tready)
        else $error("input taken during a lookup");

    // An event never appears straight after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("event too soon after input beat");

endmodule

bind per_source_packet_counter pspc_checker u_pspc_checker (.*);
